@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the lattice refinement RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, checking suspended while in reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/bspl_pkg.sv @@
// Types and constants of the B-spline lattice refinement block.
package bspl_pkg;

  localparam int MAX_SIDE    = 256;
  localparam int MIN_SIDE    = 4;
  localparam int VALUE_WIDTH = 24;
  localparam int GRID_W      = 9;
  localparam int COORD_W     = 9;
  localparam int CNT_W       = $clog2(MAX_SIDE);
  // Sums carry up to 64x the input magnitude.
  localparam int SUM_W       = VALUE_WIDTH + 7;
  localparam int RES_SLOTS   = 4;
  localparam int SLOT_CNT_W  = $clog2(RES_SLOTS + 1);

  // Filter weights and shifts.
  localparam int EDGE_WT     = 6;
  localparam int CENTER_WT   = 36;
  localparam int SHIFT_EE    = 2;
  localparam int SHIFT_OO    = 6;
  localparam int SHIFT_MIX   = 4;

  typedef logic signed [VALUE_WIDTH-1:0] val_t;
  typedef logic signed [SUM_W-1:0]       sum_t;
  typedef logic [COORD_W-1:0]            coord_t;
  typedef logic [CNT_W-1:0]              cnt_t;
  typedef logic [GRID_W-1:0]             side_t;

  // Position of an anchor: on the first row and/or first column or not.
  typedef enum logic [1:0] {
    ANC_CORNER    = 2'b00,
    ANC_FIRST_ROW = 2'b01,
    ANC_FIRST_COL = 2'b10,
    ANC_INNER     = 2'b11
  } anc_kind_t;

  // One refined coefficient waiting for the output.
  typedef struct packed {
    coord_t row;
    coord_t col;
    val_t   value;
    logic   done;
  } res_t;

endpackage

@@ rtl/core/bspl_in_if.sv @@
// Input channel: one old lattice coefficient per request.
interface bspl_in_if;
  import bspl_pkg::*;

  logic valid;
  logic ready;
  val_t coefficient;

  modport source (output valid, output coefficient, input ready);
  modport sink (input valid, input coefficient, output ready);
endinterface

@@ rtl/core/bspl_out_if.sv @@
// Result channel: one refined coefficient with its coordinates per request.
interface bspl_out_if;
  import bspl_pkg::*;

  logic   valid;
  logic   ready;
  coord_t out_row;
  coord_t out_col;
  val_t   refined_value;
  logic   grid_done;

  modport source (output valid, output out_row, output out_col,
                  output refined_value, output grid_done, input ready);
  modport sink (input valid, input out_row, input out_col,
                input refined_value, input grid_done, output ready);
endinterface

@@ rtl/core/bspl_cfg_if.sv @@
// Configuration channel: writes the side of the incoming lattice.
interface bspl_cfg_if;
  import bspl_pkg::*;

  logic  valid;
  logic  ready;
  side_t grid_side;

  modport source (output valid, output grid_side, input ready);
  modport sink (input valid, input grid_side, output ready);
endinterface

@@ rtl/core/bspl_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module bspl_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 256,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/bspline_lattice_refine.sv @@
// Top level: cubic B-spline control lattice refinement, side N to 2N-3.
//
// Usage:
//   cfg_ch writes grid_side (N, clamped to 4..256) and restarts the lattice;
//   always ready; users write it only while the block is idle, unchecked.
//   in_ch takes the old coefficients in raster order, one per request.
//   out_ch gives the refined coefficients with their row and column, up to
//   four per anchor, grid_done marking the last value of the lattice.
// Path: the request that completes an anchor is registered in the window
//   stage; its results are then loaded into the result queue.
// Flow: a request that completes no anchor (first row or column) leaves
//   no results; one that completes an anchor loads one, two or four
//   results into the result queue, which gives one result per cycle while
//   out_ch.ready is high. The next request is held in the window stage
//   meanwhile, so inner anchors take new requests only as the queue drains.
// Reset: grid_side returns to 4 and the row and column counters to zero.
//   Line buffer contents are undefined after reset but never reach a result.
// Stall: when out_ch.ready is low the result queue holds, then the window
//   stage, and then in_ch.ready drops; nothing is lost.
`include "assert_macros.svh"

module bspline_lattice_refine (
  input  logic        clk,
  input  logic        rst_n,
  bspl_in_if.sink     in_ch,
  bspl_out_if.source  out_ch,
  bspl_cfg_if.sink    cfg_ch
);
  import bspl_pkg::*;

  function automatic sum_t sx(input val_t v);
    return sum_t'(v);
  endfunction

  // Configuration register and side clamp
  side_t grid_side_r;
  side_t side_m1;
  cnt_t  last_idx;
  logic  cfg_fire;

  assign cfg_ch.ready = 1'b1;
  assign cfg_fire     = cfg_ch.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_side_r <= side_t'(MIN_SIDE);
    end else if (cfg_fire) begin
      grid_side_r <= cfg_ch.grid_side;
    end
  end

  always_comb begin
    if (grid_side_r < side_t'(MIN_SIDE)) begin
      side_m1 = side_t'(MIN_SIDE - 1);
    end else if (grid_side_r > side_t'(MAX_SIDE)) begin
      side_m1 = side_t'(MAX_SIDE - 1);
    end else begin
      side_m1 = grid_side_r - side_t'(1);
    end
  end
  assign last_idx = side_m1[CNT_W-1:0];

  // Handshake and pipeline control
  logic                  in_fire;
  logic                  out_fire;
  logic                  s1_vld_r;
  logic                  s2_free;
  logic                  s1_move;
  logic [SLOT_CNT_W-1:0] s2_cnt_r;

  assign out_fire = out_ch.valid && out_ch.ready;
  assign s2_free  = (s2_cnt_r == '0) ||
                    ((s2_cnt_r == SLOT_CNT_W'(1)) && out_fire);
  assign s1_move  = s1_vld_r && s2_free;
  assign in_ch.ready = !s1_vld_r || s2_free;
  assign in_fire  = in_ch.valid && in_ch.ready;

  // Raster counters
  cnt_t row_r, row_nxt;
  cnt_t col_r, col_nxt;

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (cfg_fire) begin
      row_nxt = '0;
      col_nxt = '0;
    end else if (in_fire) begin
      if (col_r == last_idx) begin
        col_nxt = '0;
        row_nxt = (row_r == last_idx) ? '0 : row_r + cnt_t'(1);
      end else begin
        col_nxt = col_r + cnt_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  // Line buffer: word holds {row r-2, row r-1} of a column, read one ahead
  logic [2*VALUE_WIDTH-1:0] lb_rdata;
  val_t                     upup;
  val_t                     up;

  assign upup = lb_rdata[2*VALUE_WIDTH-1:VALUE_WIDTH];
  assign up   = lb_rdata[VALUE_WIDTH-1:0];

  bspl_ram #(
    .WIDTH (2 * VALUE_WIDTH),
    .DEPTH (MAX_SIDE)
  ) u_line_ram (
    .clk   (clk),
    .we    (in_fire),
    .waddr (col_r),
    .wdata ({up, in_ch.coefficient}),
    .raddr (col_nxt),
    .rdata (lb_rdata)
  );

  // 3x3 window, shifted left on each request
  val_t win_r [9];

  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int a = 0; a < 3; a++) begin
        win_r[a*3]   <= win_r[a*3+1];
        win_r[a*3+1] <= win_r[a*3+2];
      end
      win_r[2] <= upup;
      win_r[5] <= up;
      win_r[8] <= in_ch.coefficient;
    end
  end

  // Window stage: anchor that the current window completes
  cnt_t s1_i_r, s1_j_r;
  logic s1_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_fire) begin
      s1_vld_r <= (row_r != '0) && (col_r != '0);
    end else if (s1_move) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_i_r    <= row_r - cnt_t'(1);
      s1_j_r    <= col_r - cnt_t'(1);
      s1_last_r <= (row_r == last_idx) && (col_r == last_idx);
    end
  end

  // Weighted sums of the window
  sum_t s_ee, s_oo, s_oe, s_eo;
  sum_t q_ee, q_oo, q_oe, q_eo;

  always_comb begin
    s_ee = sx(win_r[4]) + sx(win_r[5]) + sx(win_r[7]) + sx(win_r[8]);
    s_oo = sx(win_r[0]) + sx(win_r[2]) + sx(win_r[6]) + sx(win_r[8])
         + sum_t'(EDGE_WT) * (sx(win_r[1]) + sx(win_r[3]) + sx(win_r[5]) + sx(win_r[7]))
         + sum_t'(CENTER_WT) * sx(win_r[4]);
    s_oe = sx(win_r[1]) + sx(win_r[2]) + sx(win_r[7]) + sx(win_r[8])
         + sum_t'(EDGE_WT) * (sx(win_r[4]) + sx(win_r[5]));
    s_eo = sx(win_r[3]) + sx(win_r[5]) + sx(win_r[6]) + sx(win_r[8])
         + sum_t'(EDGE_WT) * (sx(win_r[4]) + sx(win_r[7]));
    q_ee = s_ee >>> SHIFT_EE;
    q_oo = s_oo >>> SHIFT_OO;
    q_oe = s_oe >>> SHIFT_MIX;
    q_eo = s_eo >>> SHIFT_MIX;
  end

  // Pack the results of the anchor in emission order
  coord_t    r_even, r_odd, c_even, c_odd;
  res_t      r_ee, r_oo, r_oe, r_eo;
  res_t      pk [RES_SLOTS];
  logic [SLOT_CNT_W-1:0] pk_cnt;
  anc_kind_t kind;

  always_comb begin
    r_even = {s1_i_r, 1'b0};
    c_even = {s1_j_r, 1'b0};
    r_odd  = r_even - coord_t'(1);
    c_odd  = c_even - coord_t'(1);
    r_ee   = '{row: r_even, col: c_even, value: q_ee[VALUE_WIDTH-1:0], done: 1'b0};
    r_oo   = '{row: r_odd,  col: c_odd,  value: q_oo[VALUE_WIDTH-1:0], done: 1'b0};
    r_oe   = '{row: r_odd,  col: c_even, value: q_oe[VALUE_WIDTH-1:0], done: 1'b0};
    r_eo   = '{row: r_even, col: c_odd,  value: q_eo[VALUE_WIDTH-1:0], done: 1'b0};
    kind   = anc_kind_t'({s1_i_r != '0, s1_j_r != '0});
    for (int k = 0; k < RES_SLOTS; k++) begin
      pk[k] = r_ee;
    end
    pk_cnt = SLOT_CNT_W'(1);
    case (kind)
      ANC_CORNER: begin
        pk[0]      = r_ee;
        pk[0].done = s1_last_r;
        pk_cnt     = SLOT_CNT_W'(1);
      end
      ANC_FIRST_ROW: begin
        pk[0]      = r_ee;
        pk[1]      = r_eo;
        pk[1].done = s1_last_r;
        pk_cnt     = SLOT_CNT_W'(2);
      end
      ANC_FIRST_COL: begin
        pk[0]      = r_ee;
        pk[1]      = r_oe;
        pk[1].done = s1_last_r;
        pk_cnt     = SLOT_CNT_W'(2);
      end
      ANC_INNER: begin
        pk[0]      = r_ee;
        pk[1]      = r_oo;
        pk[2]      = r_oe;
        pk[3]      = r_eo;
        pk[3].done = s1_last_r;
        pk_cnt     = SLOT_CNT_W'(4);
      end
      default: begin
        pk[0]  = r_ee;
        pk_cnt = SLOT_CNT_W'(1);
      end
    endcase
  end

  // Result queue: slot 0 drives the output, shifts down on each request
  res_t slot_r [RES_SLOTS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_cnt_r <= '0;
    end else if (s1_move) begin
      s2_cnt_r <= pk_cnt;
    end else if (out_fire) begin
      s2_cnt_r <= s2_cnt_r - SLOT_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      for (int k = 0; k < RES_SLOTS; k++) begin
        slot_r[k] <= pk[k];
      end
    end else if (out_fire) begin
      for (int k = 0; k < RES_SLOTS - 1; k++) begin
        slot_r[k] <= slot_r[k+1];
      end
    end
  end

  assign out_ch.valid         = (s2_cnt_r != '0);
  assign out_ch.out_row       = slot_r[0].row;
  assign out_ch.out_col       = slot_r[0].col;
  assign out_ch.refined_value = slot_r[0].value;
  assign out_ch.grid_done     = slot_r[0].done;

  // Checks
  `ASSERT_NEXT(a_load_fills, s1_move, s2_cnt_r != '0, "result queue empty after load")
  `ASSERT_IMPL(a_done_last, out_ch.valid && out_ch.grid_done, s2_cnt_r == SLOT_CNT_W'(1),
    "grid_done not on last result of anchor")
  `ASSERT_IMPL(a_hold_window, s1_vld_r && !s1_move, !in_ch.ready,
    "window overwritten before its anchor was loaded")
  `ASSERT_NEXT(a_queue_drain, out_fire && (s2_cnt_r > SLOT_CNT_W'(1)), out_ch.valid,
    "pending results lost")

endmodule

@@ bench/tb.sv @@
// Testbench for bspline_lattice_refine: random lattices checked against a local refinement model.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bspl_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 12;
  localparam int SETTLE_CYCLES = 12;
  localparam int IDLE_LIMIT    = 2000;
  localparam int REPORT_LIMIT  = 10;
  localparam int PHASES        = 9;

  localparam val_t VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam val_t VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  // Ready patterns of the result side
  typedef enum int {SINK_OPEN, SINK_COIN, SINK_BEAT, SINK_CHOKE} sink_pattern_t;

  // Refinement model: line rows, 3x3 window, raster counters and the
  // refined coefficients still owed by the block.
  class lattice_refiner;
    side_t       side_reg;
    longint      line_mem[2][MAX_SIDE];
    longint      win[3][3];
    int unsigned row_n;
    int unsigned col_n;
    res_t        due_refined[$];
    int unsigned mismatches;
    int unsigned matched;

    function new();
      side_reg   = side_t'(MIN_SIDE);
      row_n      = 0;
      col_n      = 0;
      mismatches = 0;
      matched    = 0;
      foreach (line_mem[a, b]) line_mem[a][b] = 0;
      foreach (win[a, b]) win[a][b] = 0;
    endfunction

    // A side write restarts the lattice
    function void restart(side_t side);
      side_reg = side;
      row_n    = 0;
      col_n    = 0;
    endfunction

    function void queue_refined(int unsigned row, int unsigned col, longint value);
      res_t item;
      item.row   = coord_t'(row);
      item.col   = coord_t'(col);
      item.value = val_t'(value);
      item.done  = 1'b0;
      due_refined.push_back(item);
    endfunction

    // One accepted coefficient: shift it in and owe the results of its anchor
    function void take_coefficient(val_t coef);
      int unsigned n, r, c, i, j;
      longint cur, upup, up;
      n = (side_reg < MIN_SIDE) ? MIN_SIDE : ((side_reg > MAX_SIDE) ? MAX_SIDE : side_reg);
      r = (row_n >= n) ? 0 : row_n;
      c = (col_n >= n) ? 0 : col_n;
      cur  = coef;
      upup = line_mem[0][c];
      up   = line_mem[1][c];
      line_mem[0][c] = up;
      line_mem[1][c] = cur;
      for (int a = 0; a < 3; a++) begin
        win[a][0] = win[a][1];
        win[a][1] = win[a][2];
      end
      win[0][2] = upup;
      win[1][2] = up;
      win[2][2] = cur;

      if (r >= 1 && c >= 1) begin
        i = r - 1;
        j = c - 1;
        // even-even: 2x2 average
        queue_refined(2*i, 2*j,
          (win[1][1] + win[1][2] + win[2][1] + win[2][2]) >>> SHIFT_EE);
        // odd-odd: full 3x3 stencil
        if (i != 0 && j != 0)
          queue_refined(2*i - 1, 2*j - 1,
            (win[0][0] + win[0][2] + win[2][0] + win[2][2]
             + EDGE_WT * (win[0][1] + win[1][0] + win[1][2] + win[2][1])
             + CENTER_WT * win[1][1]) >>> SHIFT_OO);
        // odd-even: vertical 1-6-1 over two columns
        if (i != 0)
          queue_refined(2*i - 1, 2*j,
            (win[0][1] + win[0][2] + win[2][1] + win[2][2]
             + EDGE_WT * (win[1][1] + win[1][2])) >>> SHIFT_MIX);
        // even-odd: horizontal 1-6-1 over two rows
        if (j != 0)
          queue_refined(2*i, 2*j - 1,
            (win[1][0] + win[1][2] + win[2][0] + win[2][2]
             + EDGE_WT * (win[1][1] + win[2][1])) >>> SHIFT_MIX);
        if (r == n - 1 && c == n - 1)
          due_refined[$].done = 1'b1;
      end

      c++;
      if (c >= n) begin
        c = 0;
        r++;
        if (r >= n) r = 0;
      end
      row_n = r;
      col_n = c;
    endfunction

    // Compare one accepted result with the oldest owed one
    function void match_refined(res_t got);
      res_t want;
      if (due_refined.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result: row %0d col %0d value %0d done %0b",
                   got.row, got.col, $signed(got.value), got.done);
        return;
      end
      want = due_refined.pop_front();
      if (got.row !== want.row || got.col !== want.col ||
          got.value !== want.value || got.done !== want.done) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display({"mismatch: expected row %0d col %0d value %0d done %0b, ",
                    "got row %0d col %0d value %0d done %0b"},
                   want.row, want.col, $signed(want.value), want.done,
                   got.row, got.col, $signed(got.value), got.done);
      end else begin
        matched++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  bspl_in_if  in_ch();
  bspl_out_if out_ch();
  bspl_cfg_if cfg_ch();

  bspline_lattice_refine u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  lattice_refiner refiner = new();

  int unsigned   sent;
  int unsigned   side_writes;
  int unsigned   burst_left;
  bit            steady_feed;
  int unsigned   idle_cycles;
  int unsigned   sink_tick;
  sink_pattern_t sink_mode = SINK_OPEN;
  side_t         side_plan [PHASES];
  int unsigned   plan_len [PHASES];

  always #CLK_HALF clk = ~clk;

  // Result side: ready follows a randomly redrawn pattern
  always @(posedge clk) begin
    sink_tick <= sink_tick + 1;
    if (sink_tick % 97 == 0)
      sink_mode <= sink_pattern_t'($urandom_range(SINK_OPEN, SINK_CHOKE));
    case (sink_mode)
      SINK_OPEN:  out_ch.ready <= 1'b1;
      SINK_COIN:  out_ch.ready <= ($urandom_range(0, 1) == 1);
      SINK_BEAT:  out_ch.ready <= (sink_tick % 4 != 3);
      default:    out_ch.ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      refiner.match_refined(res_t'{out_ch.out_row, out_ch.out_col,
                                   out_ch.refined_value, out_ch.grid_done});
  end

  // Watchdog: cycles with no request moving on any channel
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("no request moved for %0d cycles, %0d results still owed",
               IDLE_LIMIT, refiner.due_refined.size());
      $display("[bspline_lattice_refine] ERROR");
      $finish;
    end
  end

  // Send one coefficient; bursts of random length with random gaps unless steady_feed is set
  task automatic feed_coefficient(val_t coef);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = steady_feed ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid       <= 1'b1;
    in_ch.coefficient <= coef;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    refiner.take_coefficient(coef);
    sent++;
  endtask

  // Wait until every owed result came, then let trailing requests settle
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (refiner.due_refined.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_side(side_t side);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.grid_side <= side;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    refiner.restart(side);
    side_writes++;
  endtask

  function automatic val_t pick_coefficient();
    case ($urandom_range(0, 5))
      0:       return ($urandom_range(0, 1) == 1) ? VAL_MAX : VAL_MIN;
      1:       return val_t'(int'($urandom_range(0, 15)) - 8);
      default: return val_t'($urandom());
    endcase
  endfunction

  initial begin
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.coefficient <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.grid_side  <= '0;
    sent        = 0;
    side_writes = 0;
    burst_left  = 0;
    steady_feed = 1'b0;
    // side written per phase, with below-minimum and above-maximum values
    side_plan = '{9'd3, 9'd5, 9'd7, 9'd0, 9'd6, 9'd256, 9'd9, 9'd511, 9'd4};
    plan_len  = '{18, 25, 40, 16, 20, 10, 12, 10, 20};

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: side 4 from reset, a checkerboard of both extremes, then
    // the next lattice begins with the most negative value
    for (int k = 0; k < 16; k++)
      feed_coefficient(((k / 4 + k % 4) % 2 == 1) ? VAL_MIN : VAL_MAX);
    for (int k = 0; k < 9; k++)
      feed_coefficient(VAL_MIN);

    // Random phases, each restarting the lattice with a new side
    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      write_side(side_plan[p]);
      steady_feed = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < plan_len[p]; k++)
        feed_coefficient(pick_coefficient());
    end

    drain_results();
    $display("coverage: %0d coefficients over %0d side writes (sides 0..511, clamped 4..256)",
             sent, side_writes);
    $display("coverage: %0d refined values matched, full and partial lattices",
             refiner.matched);
    if (refiner.mismatches == 0 && refiner.due_refined.size() == 0)
      $display("[bspline_lattice_refine] OK");
    else
      $display("[bspline_lattice_refine] ERROR");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/bspl_pkg.sv
rtl/core/bspl_in_if.sv
rtl/core/bspl_out_if.sv
rtl/core/bspl_cfg_if.sv
rtl/core/bspl_ram.sv
rtl/core/bspline_lattice_refine.sv
bench/tb.sv
